>>> sv/coap_pkg.sv
package coap_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  payload_or_value;
        logic [2:0]  error_code;
        logic        deliver;
        logic        last_result;
    } result_t;

    // results written by one parse step, packed towards the first slot
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    localparam logic [2:0] KIND_HEADER     = 3'd0;
    localparam logic [2:0] KIND_TOKEN      = 3'd1;
    localparam logic [2:0] KIND_OPT_START  = 3'd2;
    localparam logic [2:0] KIND_OPT_VALUE  = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD    = 3'd4;
    localparam logic [2:0] KIND_DONE       = 3'd5;
    localparam logic [2:0] KIND_DROPPED    = 3'd6;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SHORT_HDR   = 3'd1;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
    localparam logic [2:0] ERR_TOKEN_LEN   = 3'd3;
    localparam logic [2:0] ERR_NIBBLE_15   = 3'd4;
    localparam logic [2:0] ERR_OPT_TRUNC   = 3'd5;
    localparam logic [2:0] ERR_TOKEN_TRUNC = 3'd6;

    localparam logic [1:0]  HDR_VERSION    = 2'd1;
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0]  NIBBLE_EXT8    = 4'd13;
    localparam logic [3:0]  NIBBLE_EXT16   = 4'd14;
    localparam logic [3:0]  NIBBLE_BAD     = 4'd15;
    localparam logic [15:0] EXT8_OFFSET    = 16'd13;
    localparam logic [15:0] EXT16_OFFSET   = 16'd269;
    localparam logic [3:0]  MAX_TOKEN_LEN  = 4'd8;

    function automatic result_t make_result(
        input logic [2:0]  kind,
        input logic [31:0] hdr,
        input logic [15:0] opt_number,
        input logic [15:0] opt_length,
        input logic [7:0]  data,
        input logic [2:0]  err,
        input logic        lst
    );
        result_t r;
        logic    is_opt;
        is_opt             = (kind == KIND_OPT_START) || (kind == KIND_OPT_VALUE);
        r.kind             = kind;
        r.msg_type         = hdr[29:28];
        r.token_length     = hdr[27:24];
        r.code             = hdr[23:16];
        r.message_id       = hdr[15:0];
        r.option_number    = is_opt ? opt_number : 16'd0;
        r.option_length    = is_opt ? opt_length : 16'd0;
        r.payload_or_value = data;
        r.error_code       = err;
        r.deliver          = (kind == KIND_DONE) && hdr[29];
        r.last_result      = lst;
        return r;
    endfunction

endpackage

>>> sv/coap_byte_if.sv
interface coap_byte_if;
    logic                   valid;
    logic                   ready;
    coap_pkg::byte_item_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/coap_result_if.sv
interface coap_result_if;
    logic               valid;
    logic               ready;
    coap_pkg::result_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/coap_step.sv
module coap_step #(
    parameter int MAX_OPTIONS       = 16,
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  coap_pkg::byte_item_t item,
    output logic                 item_ready,
    input  logic                 room,
    output coap_pkg::push_t      push,
    output coap_pkg::result_t    first_res,
    output coap_pkg::result_t    second_res
);
    import coap_pkg::*;

    localparam int W_BC = $clog2(MAX_MESSAGE_BYTES);
    localparam int W_OS = $clog2(MAX_OPTIONS + 1);

    localparam logic [2:0] PH_HDR   = 3'd0;
    localparam logic [2:0] PH_TOKEN = 3'd1;
    localparam logic [2:0] PH_OPT   = 3'd2;
    localparam logic [2:0] PH_DEXT  = 3'd3;
    localparam logic [2:0] PH_LEXT  = 3'd4;
    localparam logic [2:0] PH_VAL   = 3'd5;
    localparam logic [2:0] PH_PAY   = 3'd6;
    localparam logic [2:0] PH_TAIL  = 3'd7;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       fire;

    // parser state
    logic [2:0]      phase_reg, phase_next;
    logic [W_BC-1:0] byte_count_reg, byte_count_next;
    logic [31:0]     header_reg, header_next;
    logic [15:0]     running_reg, running_next;
    logic [W_OS-1:0] options_reg, options_next;
    logic [3:0]      delta_reg, delta_next;
    logic [3:0]      length_reg, length_next;
    logic [15:0]     ext_reg, ext_next;
    logic [15:0]     remaining_reg, remaining_next;
    logic            dropped_reg, dropped_next;

    // step results
    logic [2:0]  ph_u;
    logic [31:0] hb_u;
    logic [15:0] rn_u;
    logic [W_OS-1:0] os_u;
    logic [3:0]  dn_u;
    logic [3:0]  ln_u;
    logic [15:0] ev_u;
    logic [15:0] rc_u;
    logic [2:0]  err;
    logic        eff_last;
    logic        do_len;
    logic        do_open;
    logic        p_valid;
    logic [2:0]  p_kind;
    logic [7:0]  p_data;
    logic        f_valid;
    logic [2:0]  f_kind;
    logic        clear;
    result_t     prim_res;
    result_t     fin_res;

    assign fire       = in_valid_reg && room;
    assign item_ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            data_reg <= item.data_byte;
            last_reg <= item.last_byte;
        end
    end

    always_comb
    begin
        ph_u     = phase_reg;
        hb_u     = header_reg;
        rn_u     = running_reg;
        os_u     = options_reg;
        dn_u     = delta_reg;
        ln_u     = length_reg;
        ev_u     = ext_reg;
        rc_u     = remaining_reg;
        err      = ERR_NONE;
        do_len   = 1'b0;
        do_open  = 1'b0;
        p_valid  = 1'b0;
        p_kind   = KIND_HEADER;
        p_data   = 8'd0;
        f_valid  = 1'b0;
        f_kind   = KIND_DONE;
        eff_last = last_reg || (byte_count_reg == W_BC'(MAX_MESSAGE_BYTES - 1));

        unique case (phase_reg)
            PH_HDR:
            begin
                unique case (byte_count_reg[1:0])
                    2'd0: hb_u[31:24] = data_reg;
                    2'd1: hb_u[23:16] = data_reg;
                    2'd2: hb_u[15:8]  = data_reg;
                    2'd3: hb_u[7:0]   = data_reg;
                endcase
                if (byte_count_reg[1:0] == 2'd3)
                begin
                    if (hb_u[31:30] != HDR_VERSION)
                    begin
                        err = ERR_BAD_VERSION;
                    end
                    else if (hb_u[27:24] > MAX_TOKEN_LEN)
                    begin
                        err = ERR_TOKEN_LEN;
                    end
                    else
                    begin
                        p_valid = 1'b1;
                        p_kind  = KIND_HEADER;
                        rc_u    = {12'd0, hb_u[27:24]};
                        ph_u    = (hb_u[27:24] != 4'd0) ? PH_TOKEN : PH_OPT;
                    end
                end
            end
            PH_TOKEN:
            begin
                p_valid = 1'b1;
                p_kind  = KIND_TOKEN;
                p_data  = data_reg;
                rc_u    = remaining_reg - 16'd1;
                if (rc_u == 16'd0)
                begin
                    ph_u = PH_OPT;
                end
            end
            PH_OPT:
            begin
                if (data_reg == PAYLOAD_MARKER)
                begin
                    ph_u = PH_PAY;
                end
                else if (options_reg >= W_OS'(MAX_OPTIONS))
                begin
                    ph_u = PH_TAIL;
                end
                else if (data_reg[7:4] == NIBBLE_BAD)
                begin
                    err = ERR_NIBBLE_15;
                end
                else
                begin
                    dn_u = data_reg[7:4];
                    ln_u = data_reg[3:0];
                    ev_u = 16'd0;
                    if (dn_u >= NIBBLE_EXT8)
                    begin
                        rc_u = (dn_u == NIBBLE_EXT8) ? 16'd1 : 16'd2;
                        ph_u = PH_DEXT;
                    end
                    else
                    begin
                        rn_u   = running_reg + {12'd0, dn_u};
                        do_len = 1'b1;
                    end
                end
            end
            PH_DEXT:
            begin
                ev_u = {ext_reg[7:0], data_reg};
                rc_u = remaining_reg - 16'd1;
                if (rc_u == 16'd0)
                begin
                    rn_u   = running_reg + ev_u
                           + ((delta_reg == NIBBLE_EXT8) ? EXT8_OFFSET : EXT16_OFFSET);
                    do_len = 1'b1;
                end
            end
            PH_LEXT:
            begin
                ev_u = {ext_reg[7:0], data_reg};
                rc_u = remaining_reg - 16'd1;
                if (rc_u == 16'd0)
                begin
                    ev_u    = ev_u
                            + ((length_reg == NIBBLE_EXT8) ? EXT8_OFFSET : EXT16_OFFSET);
                    do_open = 1'b1;
                end
            end
            PH_VAL:
            begin
                p_valid = 1'b1;
                p_kind  = KIND_OPT_VALUE;
                p_data  = data_reg;
                rc_u    = remaining_reg - 16'd1;
                if (rc_u == 16'd0)
                begin
                    ph_u = PH_OPT;
                end
            end
            PH_PAY:
            begin
                p_valid = 1'b1;
                p_kind  = KIND_PAYLOAD;
                p_data  = data_reg;
            end
            PH_TAIL:
            begin
                ph_u = PH_TAIL;
            end
        endcase

        // length nibble handling once the delta is known
        if (do_len)
        begin
            if (ln_u == NIBBLE_BAD)
            begin
                err = ERR_NIBBLE_15;
            end
            else if (ln_u >= NIBBLE_EXT8)
            begin
                ev_u = 16'd0;
                rc_u = (ln_u == NIBBLE_EXT8) ? 16'd1 : 16'd2;
                ph_u = PH_LEXT;
            end
            else
            begin
                ev_u    = {12'd0, ln_u};
                do_open = 1'b1;
            end
        end

        if (do_open)
        begin
            os_u    = options_reg + W_OS'(1);
            p_valid = 1'b1;
            p_kind  = KIND_OPT_START;
            rc_u    = ev_u;
            ph_u    = (ev_u != 16'd0) ? PH_VAL : PH_OPT;
        end

        if ((err == ERR_NONE) && eff_last)
        begin
            priority if (ph_u == PH_HDR)
            begin
                err = ERR_SHORT_HDR;
            end
            else if (ph_u == PH_TOKEN)
            begin
                err = ERR_TOKEN_TRUNC;
            end
            else if ((ph_u == PH_DEXT) || (ph_u == PH_LEXT) || (ph_u == PH_VAL))
            begin
                err = ERR_OPT_TRUNC;
            end
            else
            begin
                f_valid = 1'b1;
                f_kind  = KIND_DONE;
            end
        end
        if (err != ERR_NONE)
        begin
            f_valid = 1'b1;
            f_kind  = KIND_DROPPED;
        end
        clear = f_valid;
        if (dropped_reg)
        begin
            p_valid = 1'b0;
            f_valid = 1'b0;
        end
    end

    assign prim_res = make_result(p_kind, hb_u, rn_u, ev_u, p_data, ERR_NONE, !f_valid);
    assign fin_res  = make_result(f_kind, hb_u, 16'd0, 16'd0, 8'd0, err, 1'b1);

    assign push.first  = fire && (p_valid || f_valid);
    assign push.second = fire && p_valid && f_valid;
    assign first_res   = p_valid ? prim_res : fin_res;
    assign second_res  = fin_res;

    always_comb
    begin
        phase_next      = ph_u;
        byte_count_next = byte_count_reg + W_BC'(1);
        header_next     = hb_u;
        running_next    = rn_u;
        options_next    = os_u;
        delta_next      = dn_u;
        length_next     = ln_u;
        ext_next        = ev_u;
        remaining_next  = rc_u;
        dropped_next    = 1'b0;
        if (dropped_reg || clear)
        begin
            phase_next      = PH_HDR;
            byte_count_next = '0;
            header_next     = 32'd0;
            running_next    = 16'd0;
            options_next    = '0;
            delta_next      = 4'd0;
            length_next     = 4'd0;
            ext_next        = 16'd0;
            remaining_next  = 16'd0;
            dropped_next    = dropped_reg ? !last_reg : !last_reg;
        end
        if (dropped_reg && !last_reg)
        begin
            dropped_next = 1'b1;
        end
        else if (dropped_reg)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            byte_count_reg <= '0;
            header_reg     <= 32'd0;
            running_reg    <= 16'd0;
            options_reg    <= '0;
            delta_reg      <= 4'd0;
            length_reg     <= 4'd0;
            ext_reg        <= 16'd0;
            remaining_reg  <= 16'd0;
            dropped_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            header_reg     <= header_next;
            running_reg    <= running_next;
            options_reg    <= options_next;
            delta_reg      <= delta_next;
            length_reg     <= length_next;
            ext_reg        <= ext_next;
            remaining_reg  <= remaining_next;
            dropped_reg    <= dropped_next;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second result without a first");

    a_dropped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> !push.first)
        else $error("result written while discarding a datagram");

    a_token_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TOKEN) |-> (remaining_reg != 16'd0))
        else $error("token phase with nothing left to read");

endmodule

>>> sv/coap_out_stage.sv
module coap_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  coap_pkg::push_t   push,
    input  coap_pkg::result_t first_res,
    input  coap_pkg::result_t second_res,
    output logic              room,
    output logic              res_valid,
    output coap_pkg::result_t res_payload,
    input  logic              res_ready
);
    import coap_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    spare_valid_reg, spare_valid_next;
    result_t spare_reg, spare_next;
    logic    pop;
    logic    out_free;

    assign pop      = out_valid_reg && res_ready;
    assign out_free = !out_valid_reg || pop;
    assign room     = !spare_valid_reg && out_free;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        priority if (spare_valid_reg && out_free)
        begin
            out_valid_next   = 1'b1;
            out_next         = spare_reg;
            spare_valid_next = 1'b0;
        end
        else if (push.first)
        begin
            out_valid_next = 1'b1;
            out_next       = first_res;
            if (push.second)
            begin
                spare_valid_next = 1'b1;
                spare_next       = second_res;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    assign res_valid   = out_valid_reg;
    assign res_payload = out_reg;

    a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> out_valid_reg)
        else $error("spare result held with empty output register");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> room)
        else $error("result written with no room");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_reg.kind == KIND_DONE) || (out_reg.kind == KIND_DROPPED)))
        |-> out_reg.last_result)
        else $error("done or dropped result not marked last");

endmodule

>>> sv/coap_message_parser.sv
// channel    dir  handshake     payload
// datagram   in   valid/ready   data_byte, last_byte
// result     out  valid/ready   kind .. last_result (one result per transfer)
//
// one datagram byte per cycle while the result side has room; a byte that gives
// two results (any result followed by done or dropped) holds the input while
// the second result leaves through the spare register
// a byte is held in the input register, its first result in the output register
// reset returns the parser to the header phase and empties the input, output and spare registers
// a stalled result side keeps the byte in the input register and backs up the input
module coap_message_parser #(
    parameter int MAX_OPTIONS       = 16,
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    coap_byte_if.sink         datagram,
    coap_result_if.source     result
);
    import coap_pkg::*;

    logic    room;
    push_t   push;
    result_t first_res;
    result_t second_res;

    coap_step #(
        .MAX_OPTIONS       (MAX_OPTIONS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (datagram.valid),
        .item       (datagram.payload),
        .item_ready (datagram.ready),
        .room       (room),
        .push       (push),
        .first_res  (first_res),
        .second_res (second_res)
    );

    coap_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .first_res   (first_res),
        .second_res  (second_res),
        .room        (room),
        .res_valid   (result.valid),
        .res_payload (result.payload),
        .res_ready   (result.ready)
    );

endmodule

>>> sim/tb_coap_message_parser.sv
module tb_coap_message_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import coap_pkg::*;

    localparam int MAX_OPTIONS       = 16;
    localparam int MAX_MESSAGE_BYTES = 256;
    localparam int IDLE_PCT          = 29;
    localparam int HOLD_CYCLES       = 300;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int SETTLE_CYCLES     = 10;
    localparam int MAX_REPORTS       = 40;
    localparam int STEADY_BYTES      = 400;
    localparam int RANDOM_BYTES      = 550;
    localparam int TX_BACKLOG        = 32;

    localparam logic [1:0] TYPE_CON   = 2'd0;
    localparam logic [1:0] TYPE_NON   = 2'd1;
    localparam logic [1:0] TYPE_ACK   = 2'd2;
    localparam logic [1:0] TYPE_RESET = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TOKEN,
        PH_OPTION,
        PH_DELTA_EXT,
        PH_LENGTH_EXT,
        PH_VALUE,
        PH_PAYLOAD,
        PH_SKIP
    } parse_phase_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    coap_byte_if   datagram_if ();
    coap_result_if result_if ();

    coap_message_parser #(
        .MAX_OPTIONS       (MAX_OPTIONS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .datagram (datagram_if),
        .result   (result_if)
    );

    always #1 clk = ~clk;

    // parser state mirrored for prediction
    parse_phase_e phase;
    logic [16:0]  byte_cnt;
    logic [31:0]  hdr;
    logic [15:0]  opt_number;
    logic [6:0]   opt_count;
    logic [3:0]   delta_nib;
    logic [3:0]   length_nib;
    logic [15:0]  ext_value;
    logic [16:0]  remaining;
    logic         discarding;

    result_t      step_out[$];
    result_t      due_results[$];
    byte_item_t   tx_bytes[$];
    logic [7:0]   frame[$];

    int   bytes_queued = 0;
    int   bytes_taken  = 0;
    int   bytes_parsed = 0;
    int   results_seen = 0;
    int   errors       = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_used    = 1'b0;
    logic hold_req     = 1'b0;
    logic steady       = 1'b0;
    logic in_taken     = 1'b0;

    function automatic void clear_parser();
        phase      = PH_HEADER;
        byte_cnt   = '0;
        hdr        = '0;
        opt_number = '0;
        opt_count  = '0;
        delta_nib  = '0;
        length_nib = '0;
        ext_value  = '0;
        remaining  = '0;
        discarding = 1'b0;
    endfunction

    initial clear_parser();

    function automatic void push_result(input logic [2:0] kind, input logic [7:0] data,
                                        input logic [2:0] err);
        result_t r;
        r                  = '0;
        r.kind             = kind;
        r.msg_type         = hdr[29:28];
        r.token_length     = hdr[27:24];
        r.code             = hdr[23:16];
        r.message_id       = hdr[15:0];
        if (kind == KIND_OPT_START || kind == KIND_OPT_VALUE)
        begin
            r.option_number = opt_number;
            r.option_length = ext_value;
        end
        r.payload_or_value = data;
        r.error_code       = err;
        r.deliver          = (kind == KIND_DONE) && (hdr[29:28] >= TYPE_ACK);
        step_out.push_back(r);
    endfunction

    function automatic void open_option();
        opt_count = opt_count + 7'd1;
        push_result(KIND_OPT_START, 8'd0, ERR_NONE);
        remaining = 17'(ext_value);
        phase     = (remaining != 0) ? PH_VALUE : PH_OPTION;
    endfunction

    function automatic logic [2:0] begin_length();
        if (length_nib == NIBBLE_BAD)
            return ERR_NIBBLE_15;
        if (length_nib >= NIBBLE_EXT8)
        begin
            ext_value = '0;
            remaining = (length_nib == NIBBLE_EXT8) ? 17'd1 : 17'd2;
            phase     = PH_LENGTH_EXT;
        end
        else
        begin
            ext_value = 16'(length_nib);
            open_option();
        end
        return ERR_NONE;
    endfunction

    function automatic void parse_byte(input byte_item_t item);
        logic [7:0]  b;
        logic        eff_last;
        logic [2:0]  err;
        logic [16:0] idx;
        logic [15:0] add;
        result_t     tail;
        b   = item.data_byte;
        err = ERR_NONE;
        if (discarding)
        begin
            if (item.last_byte)
                clear_parser();
            return;
        end
        bytes_parsed++;
        idx      = byte_cnt;
        eff_last = item.last_byte || (int'(byte_cnt) + 1 >= MAX_MESSAGE_BYTES);
        if (byte_cnt != 17'h1FFFF)
            byte_cnt = byte_cnt + 17'd1;

        case (phase)
            PH_HEADER:
            begin
                hdr[8 * (3 - int'(idx[1:0])) +: 8] = b;
                if (idx[1:0] == 2'd3)
                begin
                    if (hdr[31:30] != HDR_VERSION)
                        err = ERR_BAD_VERSION;
                    else if (hdr[27:24] > MAX_TOKEN_LEN)
                        err = ERR_TOKEN_LEN;
                    else
                    begin
                        push_result(KIND_HEADER, 8'd0, ERR_NONE);
                        remaining = 17'(hdr[27:24]);
                        phase     = (hdr[27:24] != 0) ? PH_TOKEN : PH_OPTION;
                    end
                end
            end
            PH_TOKEN:
            begin
                push_result(KIND_TOKEN, b, ERR_NONE);
                remaining = remaining - 17'd1;
                if (remaining == 0)
                    phase = PH_OPTION;
            end
            PH_OPTION:
            begin
                if (b == PAYLOAD_MARKER)
                    phase = PH_PAYLOAD;
                else if (opt_count >= MAX_OPTIONS)
                    phase = PH_SKIP;
                else if (b[7:4] == NIBBLE_BAD)
                    err = ERR_NIBBLE_15;
                else
                begin
                    delta_nib  = b[7:4];
                    length_nib = b[3:0];
                    ext_value  = '0;
                    if (delta_nib >= NIBBLE_EXT8)
                    begin
                        remaining = (delta_nib == NIBBLE_EXT8) ? 17'd1 : 17'd2;
                        phase     = PH_DELTA_EXT;
                    end
                    else
                    begin
                        opt_number = opt_number + 16'(delta_nib);
                        err        = begin_length();
                    end
                end
            end
            PH_DELTA_EXT:
            begin
                ext_value = {ext_value[7:0], b};
                remaining = remaining - 17'd1;
                if (remaining == 0)
                begin
                    add        = (delta_nib == NIBBLE_EXT8) ? EXT8_OFFSET : EXT16_OFFSET;
                    opt_number = opt_number + ext_value + add;
                    err        = begin_length();
                end
            end
            PH_LENGTH_EXT:
            begin
                ext_value = {ext_value[7:0], b};
                remaining = remaining - 17'd1;
                if (remaining == 0)
                begin
                    add       = (length_nib == NIBBLE_EXT8) ? EXT8_OFFSET : EXT16_OFFSET;
                    ext_value = ext_value + add;
                    open_option();
                end
            end
            PH_VALUE:
            begin
                push_result(KIND_OPT_VALUE, b, ERR_NONE);
                remaining = remaining - 17'd1;
                if (remaining == 0)
                    phase = PH_OPTION;
            end
            PH_PAYLOAD:
                push_result(KIND_PAYLOAD, b, ERR_NONE);
            default:
                ;
        endcase

        if (err == ERR_NONE && eff_last)
        begin
            if (phase == PH_HEADER)
                err = ERR_SHORT_HDR;
            else if (phase == PH_TOKEN)
                err = ERR_TOKEN_TRUNC;
            else if (phase == PH_DELTA_EXT || phase == PH_LENGTH_EXT || phase == PH_VALUE)
                err = ERR_OPT_TRUNC;
            else
                push_result(KIND_DONE, 8'd0, ERR_NONE);
        end
        if (err != ERR_NONE)
            push_result(KIND_DROPPED, 8'd0, err);
        if (err != ERR_NONE || eff_last)
        begin
            clear_parser();
            if (!item.last_byte)
                discarding = 1'b1;
        end

        if (step_out.size() != 0)
        begin
            tail             = step_out.pop_back();
            tail.last_result = 1'b1;
            step_out.push_back(tail);
            foreach (step_out[i])
                due_results.push_back(step_out[i]);
            step_out.delete();
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            if (errors < MAX_REPORTS)
                $display("%0t: result %0d %s expected %0h actual %0h",
                         $time, results_seen, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        want = due_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(got.kind));
        check_field("msg_type", 16'(want.msg_type), 16'(got.msg_type));
        check_field("token_length", 16'(want.token_length), 16'(got.token_length));
        check_field("code", 16'(want.code), 16'(got.code));
        check_field("message_id", want.message_id, got.message_id);
        check_field("option_number", want.option_number, got.option_number);
        check_field("option_length", want.option_length, got.option_length);
        check_field("payload_or_value", 16'(want.payload_or_value),
                    16'(got.payload_or_value));
        check_field("error_code", 16'(want.error_code), 16'(got.error_code));
        check_field("deliver", 16'(want.deliver), 16'(got.deliver));
        check_field("last_result", 16'(want.last_result), 16'(got.last_result));
    endtask

    // both channels sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= datagram_if.valid && datagram_if.ready;
            if (datagram_if.valid && datagram_if.ready)
            begin
                parse_byte(datagram_if.payload);
                bytes_taken++;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (due_results.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: result %0d expected none actual kind %0d",
                                 $time, results_seen, result_if.payload.kind);
                    errors++;
                end
                else
                    check_result(result_if.payload);
                results_seen++;
            end
            if ((datagram_if.valid && datagram_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!datagram_if.valid || in_taken))
        begin
            if (tx_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                datagram_if.valid   <= 1'b1;
                datagram_if.payload <= tx_bytes.pop_front();
            end
            else
                datagram_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used       <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void put_header(input logic [1:0] ver, input logic [1:0] mtype,
                                       input logic [3:0] tkl, input logic [7:0] code,
                                       input logic [15:0] mid);
        frame.push_back({ver, mtype, tkl});
        frame.push_back(code);
        frame.push_back(mid[15:8]);
        frame.push_back(mid[7:0]);
    endfunction

    function automatic void put_random(input int n);
        for (int i = 0; i < n; i++)
            frame.push_back(8'($urandom));
    endfunction

    function automatic logic [3:0] ext_nibble(input int v);
        if (v < 13)
            return 4'(v);
        return (v < 269) ? NIBBLE_EXT8 : NIBBLE_EXT16;
    endfunction

    function automatic void push_ext(input int v);
        if (v >= 269)
        begin
            frame.push_back(8'((v - 269) >> 8));
            frame.push_back(8'(v - 269));
        end
        else if (v >= 13)
            frame.push_back(8'(v - 13));
    endfunction

    function automatic void put_option(input int delta, input int len, input int n_value);
        frame.push_back({ext_nibble(delta), ext_nibble(len)});
        push_ext(delta);
        push_ext(len);
        put_random(n_value);
    endfunction

    function automatic void send_frame(input int count);
        byte_item_t item;
        for (int i = 0; i < count; i++)
        begin
            item.data_byte = frame[i];
            item.last_byte = (i == count - 1);
            tx_bytes.push_back(item);
        end
        bytes_queued += count;
        frame.delete();
    endfunction

    // mostly well-formed datagrams, some cut short, damaged or pure noise
    function automatic void build_random_frame();
        int tkl;
        int n_opts;
        int delta;
        int len;
        int sel;
        int count;
        tkl = $urandom_range(8);
        put_header(HDR_VERSION, 2'($urandom), 4'(tkl), 8'($urandom), 16'($urandom));
        put_random(tkl);
        n_opts = ($urandom_range(99) < 10) ? $urandom_range(20, 14) : $urandom_range(5);
        for (int i = 0; i < n_opts; i++)
        begin
            sel   = $urandom_range(99);
            delta = (sel < 60) ? $urandom_range(12) :
                    (sel < 90) ? $urandom_range(268, 13) : $urandom_range(65535, 269);
            sel   = $urandom_range(99);
            len   = (sel < 70) ? $urandom_range(12) :
                    (sel < 99) ? $urandom_range(30, 13) : $urandom_range(320, 269);
            put_option(delta, len, len);
        end
        if ($urandom_range(1) != 0)
        begin
            frame.push_back(PAYLOAD_MARKER);
            put_random(($urandom_range(99) == 0) ? $urandom_range(300, 200) : $urandom_range(20));
        end
        sel = $urandom_range(99);
        if (sel < 5)
            frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
        else if (sel < 8)
            frame[0] = 8'($urandom);
        else if (sel < 11)
        begin
            frame.delete();
            put_random($urandom_range(12, 1));
        end
        else if (sel < 14)
            put_random($urandom_range(6, 1));
        count = frame.size();
        if (sel >= 14 && sel < 20)
            count = $urandom_range(frame.size() - 1, 1);
        send_frame(count);
    endfunction

    task automatic fill_random(input int target);
        while (bytes_parsed < target)
        begin
            build_random_frame();
            while (tx_bytes.size() > TX_BACKLOG)
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken < bytes_queued || due_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int start;
        datagram_if.valid   = 1'b0;
        datagram_if.payload = '0;
        result_if.ready     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // header alone, ending on its last byte
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0000);
        send_frame(frame.size());

        // full token, extended deltas, wrapping number and a payload
        put_header(HDR_VERSION, TYPE_ACK, MAX_TOKEN_LEN, 8'hFF, 16'hFFFF);
        frame.push_back(8'h00);
        frame.push_back(8'hFF);
        put_random(6);
        put_option(0, 0, 0);
        put_option(12, 12, 12);
        put_option(13, 13, 13);
        put_option(268, 14, 14);
        put_option(269, 1, 1);
        put_option(65535, 2, 2);
        frame.push_back(PAYLOAD_MARKER);
        frame.push_back(8'h00);
        frame.push_back(8'hFF);
        frame.push_back(8'h5A);
        send_frame(frame.size());

        // payload marker as the final byte
        put_header(HDR_VERSION, TYPE_RESET, 4'd0, 8'h45, 16'h1234);
        frame.push_back(PAYLOAD_MARKER);
        send_frame(frame.size());

        // token ending the datagram
        put_header(HDR_VERSION, TYPE_NON, 4'd1, 8'h02, 16'h8001);
        put_random(1);
        send_frame(frame.size());

        // header promising a token, then the end
        put_header(HDR_VERSION, TYPE_CON, 4'd3, 8'h03, 16'h00FF);
        send_frame(frame.size());

        // short headers
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0001);
        send_frame(2);
        frame.push_back(8'h00);
        send_frame(1);

        // wrong versions, the last one on the final byte
        for (int v = 0; v < 4; v++)
        begin
            if (v != HDR_VERSION)
            begin
                put_header(2'(v), TYPE_ACK, 4'd0, 8'h01, 16'h0002);
                if (v != 3)
                    put_random(3);
                send_frame(frame.size());
            end
        end

        // token length over the limit
        put_header(HDR_VERSION, TYPE_CON, MAX_TOKEN_LEN + 4'd1, 8'h01, 16'h0003);
        put_random(9);
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_CON, 4'd15, 8'h01, 16'h0004);
        send_frame(frame.size());

        // nibble fifteen in delta, in length, and after a delta extension
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0005);
        frame.push_back({NIBBLE_BAD, 4'd0});
        put_random(2);
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0006);
        frame.push_back({4'd1, NIBBLE_BAD});
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0007);
        frame.push_back({NIBBLE_EXT8, NIBBLE_BAD});
        frame.push_back(8'h00);
        put_random(1);
        send_frame(frame.size());

        // delta extension cut short takes precedence over a bad length nibble
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0008);
        frame.push_back({NIBBLE_EXT8, NIBBLE_BAD});
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0009);
        frame.push_back({NIBBLE_EXT16, 4'd0});
        frame.push_back(8'h01);
        send_frame(frame.size());

        // option value and length extension cut short
        put_header(HDR_VERSION, TYPE_NON, 4'd0, 8'h01, 16'h000A);
        frame.push_back({4'd0, 4'd3});
        put_random(2);
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_NON, 4'd0, 8'h01, 16'h000B);
        frame.push_back({4'd0, NIBBLE_EXT8});
        send_frame(frame.size());

        // length wraps round, then the value is cut short
        put_header(HDR_VERSION, TYPE_NON, 4'd0, 8'h01, 16'h000C);
        frame.push_back({4'd0, NIBBLE_EXT16});
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        put_random(3);
        send_frame(frame.size());

        // token cut short
        put_header(HDR_VERSION, TYPE_CON, 4'd4, 8'h01, 16'h000D);
        put_random(2);
        send_frame(frame.size());

        // option limit: a further option skips to the end, a marker still opens a payload
        put_header(HDR_VERSION, TYPE_ACK, 4'd0, 8'h01, 16'h000E);
        for (int i = 0; i < MAX_OPTIONS; i++)
            put_option(0, 0, 0);
        frame.push_back(8'h11);
        put_random(3);
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_ACK, 4'd0, 8'h01, 16'h000F);
        for (int i = 0; i < MAX_OPTIONS; i++)
            put_option(1, 0, 0);
        frame.push_back(PAYLOAD_MARKER);
        put_random(2);
        send_frame(frame.size());

        // byte limit: over, exactly at, and one past
        put_header(HDR_VERSION, TYPE_CON, 4'd0, 8'h01, 16'h0010);
        frame.push_back(PAYLOAD_MARKER);
        put_random(300);
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_RESET, 4'd0, 8'h01, 16'h0011);
        frame.push_back(PAYLOAD_MARKER);
        put_random(MAX_MESSAGE_BYTES - 5);
        send_frame(frame.size());
        put_header(HDR_VERSION, TYPE_NON, 4'd0, 8'h01, 16'h0012);
        put_option(5, 65535, 30);
        put_random(MAX_MESSAGE_BYTES);
        send_frame(MAX_MESSAGE_BYTES + 1);

        // sender pauses until every result is back
        wait_drained();
        start = bytes_parsed;

        // no idling; receiver holds off while the sender keeps going
        steady   = 1'b1;
        hold_req = 1'b1;
        fill_random(start + STEADY_BYTES);
        wait_drained();
        steady = 1'b0;

        fill_random(start + RANDOM_BYTES);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
sv/coap_pkg.sv
sv/coap_byte_if.sv
sv/coap_result_if.sv
sv/coap_step.sv
sv/coap_out_stage.sv
sv/coap_message_parser.sv
sim/tb_coap_message_parser.sv
